// ===== hdl/assert_macros.svh =====
// Assertion macros used by the decoder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/irpd_pkg.sv =====
// Types and constants of the pulse-distance IR bit decoder.
package irpd_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int TICK_WIDTH  = 16;

    localparam int FIELD_W     = 16;
    localparam int T_W         = (TICK_WIDTH < FIELD_W) ? TICK_WIDTH : FIELD_W;
    localparam int TOL_W       = 7;
    localparam int TOL_RESET   = 20;

    localparam int PCT_SCALE   = 100;
    localparam int ONE_PARTS   = 4;
    localparam int ZERO_PARTS  = 2;
    localparam int BYTE_BITS   = 8;

    // bound = parts * (100 + tol) with tol < 128
    localparam int BOUND_W     = 10;
    localparam int PROD_W      = T_W + BOUND_W;

    localparam int IN_TDATA_W  = 2 * FIELD_W;
    localparam int IDX_W       = 5;
    localparam int BITS_W      = 4;
    localparam int OUT_FIELD_W = BYTE_BITS + IDX_W + BITS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam int BITPOS_W    = $clog2(BYTE_BITS);
    localparam int BYTEPOS_W   = $clog2(FRAME_BYTES) + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_ZERO    = 2'd0,
        KIND_ONE     = 2'd1,
        KIND_INVALID = 2'd2
    } t_cell_kind;

    typedef struct packed {
        logic       is_start;
        t_cell_kind kind;
    } t_cell_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic [BITS_W-1:0]    bits_valid;
        logic [IDX_W-1:0]     byte_index;
        logic [BYTE_BITS-1:0] byte_value;
    } t_out_item;

endpackage

// ===== hdl/irpd_front.sv =====
// Front end: takes cells, cross-multiplies against the tolerance window, classifies.
module irpd_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [irpd_pkg::TOL_W-1:0]           i_cfg_data,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [irpd_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    input  logic                                 i_s_tuser,
    input  irpd_pkg::t_q_status                  i_q_status,
    output logic                                 o_push,
    output irpd_pkg::t_cell_cmd                  o_push_cmd
);

    logic [irpd_pkg::TOL_W-1:0]   r_tol;

    logic                         r_a_valid;
    logic                         r_start;
    logic                         r_mark_zero;
    logic [irpd_pkg::PROD_W-1:0]  r_p100;
    logic [irpd_pkg::PROD_W-1:0]  r_hi1m;
    logic [irpd_pkg::PROD_W-1:0]  r_lo1m;
    logic                         r_lo1_pass;
    logic [irpd_pkg::PROD_W-1:0]  r_hi0m;
    logic [irpd_pkg::PROD_W-1:0]  r_lo0m;
    logic                         r_lo0_pass;

    logic [irpd_pkg::T_W-1:0]     w_mark;
    logic [irpd_pkg::T_W-1:0]     w_period;
    logic [irpd_pkg::BOUND_W-1:0] w_hi1;
    logic [irpd_pkg::BOUND_W-1:0] w_hi0;
    logic signed [irpd_pkg::BOUND_W:0] w_lo1;
    logic signed [irpd_pkg::BOUND_W:0] w_lo0;
    logic                         w_advance;
    logic                         w_load;
    logic                         w_is_one;
    logic                         w_is_zero;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= irpd_pkg::TOL_W'(irpd_pkg::TOL_RESET);
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_data;
        end
    end

    assign w_mark   = i_s_tdata[irpd_pkg::T_W-1:0];
    assign w_period = i_s_tdata[irpd_pkg::FIELD_W +: irpd_pkg::T_W];

    // window bounds; the lower one is lo+1 and may go to zero or below
    assign w_hi1 = irpd_pkg::BOUND_W'(irpd_pkg::ONE_PARTS * (irpd_pkg::PCT_SCALE + int'(r_tol)));
    assign w_hi0 = irpd_pkg::BOUND_W'(irpd_pkg::ZERO_PARTS * (irpd_pkg::PCT_SCALE + int'(r_tol)));
    assign w_lo1 = (irpd_pkg::BOUND_W + 1)'(
        irpd_pkg::ONE_PARTS * (irpd_pkg::PCT_SCALE - int'(r_tol)) + 1);
    assign w_lo0 = (irpd_pkg::BOUND_W + 1)'(
        irpd_pkg::ZERO_PARTS * (irpd_pkg::PCT_SCALE - int'(r_tol)) + 1);

    assign w_advance  = !r_a_valid || !i_q_status.full;
    assign o_s_tready = w_advance;
    assign w_load     = i_s_tvalid && w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_advance) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_start     <= i_s_tuser;
            r_mark_zero <= (w_mark == '0);
            r_p100      <= irpd_pkg::PROD_W'(w_period) * irpd_pkg::PROD_W'(irpd_pkg::PCT_SCALE);
            r_hi1m      <= irpd_pkg::PROD_W'(w_hi1) * irpd_pkg::PROD_W'(w_mark);
            r_hi0m      <= irpd_pkg::PROD_W'(w_hi0) * irpd_pkg::PROD_W'(w_mark);
            r_lo1m      <= irpd_pkg::PROD_W'(w_lo1[irpd_pkg::BOUND_W-1:0])
                           * irpd_pkg::PROD_W'(w_mark);
            r_lo0m      <= irpd_pkg::PROD_W'(w_lo0[irpd_pkg::BOUND_W-1:0])
                           * irpd_pkg::PROD_W'(w_mark);
            // a non-positive lower bound always passes
            r_lo1_pass  <= (w_lo1 <= 0);
            r_lo0_pass  <= (w_lo0 <= 0);
        end
    end

    assign w_is_one  = !r_mark_zero && (r_p100 < r_hi1m) && (r_lo1_pass || r_p100 >= r_lo1m);
    assign w_is_zero = !r_mark_zero && (r_p100 < r_hi0m) && (r_lo0_pass || r_p100 >= r_lo0m);

    always_comb begin
        o_push              = r_a_valid && !i_q_status.full;
        o_push_cmd.is_start = r_start;
        if (w_is_one) begin
            o_push_cmd.kind = irpd_pkg::KIND_ONE;
        end else if (w_is_zero) begin
            o_push_cmd.kind = irpd_pkg::KIND_ZERO;
        end else begin
            o_push_cmd.kind = irpd_pkg::KIND_INVALID;
        end
    end

endmodule

// ===== hdl/irpd_queue.sv =====
// Short FIFO of classified cells between front and back.
module irpd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  irpd_pkg::t_cell_cmd   i_push_cmd,
    input  logic                  i_pop,
    output irpd_pkg::t_cell_cmd   o_head_cmd,
    output irpd_pkg::t_q_status   o_status
);

    irpd_pkg::t_cell_cmd           r_entries [irpd_pkg::QUEUE_DEPTH];
    logic [irpd_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [irpd_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [irpd_pkg::QUEUE_CW-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == irpd_pkg::QUEUE_CW'(irpd_pkg::QUEUE_DEPTH));
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head_cmd = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entries[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/irpd_back.sv =====
// Back end: frame tracking, LSB-first byte packing and the output register.
module irpd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  irpd_pkg::t_q_status   i_q_status,
    input  irpd_pkg::t_cell_cmd   i_head_cmd,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output irpd_pkg::t_out_item   o_item,
    output logic                  o_last
);

    logic                              r_skip_leader;
    logic                              r_stopped;
    logic [irpd_pkg::BITPOS_W-1:0]     r_bit_pos;
    logic [irpd_pkg::BYTEPOS_W-1:0]    r_byte_pos;
    logic [irpd_pkg::BYTE_BITS-1:0]    r_partial;
    logic                              r_out_valid;
    irpd_pkg::t_out_item               r_out_item;
    logic                              r_out_last;

    logic                              n_skip_leader;
    logic                              n_stopped;
    logic [irpd_pkg::BITPOS_W-1:0]     n_bit_pos;
    logic [irpd_pkg::BYTEPOS_W-1:0]    n_byte_pos;
    logic [irpd_pkg::BYTE_BITS-1:0]    n_partial;
    logic                              n_emit;
    irpd_pkg::t_out_item               n_out_item;
    logic                              n_out_last;

    logic [irpd_pkg::BYTE_BITS-1:0]    w_with_bit;
    logic                              w_limit;

    assign o_pop   = !i_q_status.empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;
    assign o_last  = r_out_last;

    assign w_limit = (r_byte_pos + 1'b1) >= irpd_pkg::BYTEPOS_W'(irpd_pkg::FRAME_BYTES);

    always_comb begin
        w_with_bit             = r_partial;
        w_with_bit[r_bit_pos]  = (i_head_cmd.kind == irpd_pkg::KIND_ONE);

        n_skip_leader          = r_skip_leader;
        n_stopped              = r_stopped;
        n_bit_pos              = r_bit_pos;
        n_byte_pos             = r_byte_pos;
        n_partial              = r_partial;
        n_emit                 = 1'b0;
        n_out_last             = 1'b0;
        n_out_item.byte_value  = r_partial;
        n_out_item.byte_index  = r_byte_pos[irpd_pkg::IDX_W-1:0];
        n_out_item.bits_valid  = irpd_pkg::BITS_W'(r_bit_pos);

        if (i_head_cmd.is_start) begin
            n_skip_leader = 1'b1;
            n_stopped     = 1'b0;
            n_bit_pos     = '0;
            n_byte_pos    = '0;
            n_partial     = '0;
        end else if (r_stopped) begin
            n_stopped = 1'b1;
        end else if (r_skip_leader) begin
            n_skip_leader = 1'b0;
        end else if (i_head_cmd.kind == irpd_pkg::KIND_INVALID) begin
            // partial byte goes out as the frame's final item
            n_emit     = 1'b1;
            n_out_last = 1'b1;
            n_stopped  = 1'b1;
        end else if (r_bit_pos == irpd_pkg::BITPOS_W'(irpd_pkg::BYTE_BITS - 1)) begin
            n_emit                = 1'b1;
            n_out_last            = w_limit;
            n_out_item.byte_value = w_with_bit;
            n_out_item.bits_valid = irpd_pkg::BITS_W'(irpd_pkg::BYTE_BITS);
            n_bit_pos             = '0;
            n_partial             = '0;
            n_byte_pos            = r_byte_pos + 1'b1;
            n_stopped             = w_limit;
        end else begin
            n_bit_pos = r_bit_pos + 1'b1;
            n_partial = w_with_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skip_leader <= 1'b0;
            r_stopped     <= 1'b1;
            r_bit_pos     <= '0;
            r_byte_pos    <= '0;
            r_partial     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_skip_leader <= n_skip_leader;
                r_stopped     <= n_stopped;
                r_bit_pos     <= n_bit_pos;
                r_byte_pos    <= n_byte_pos;
                r_partial     <= n_partial;
                r_out_valid   <= n_emit;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && n_emit) begin
            r_out_item <= n_out_item;
            r_out_last <= n_out_last;
        end
    end

endmodule

// ===== hdl/ir_pulse_distance_bit_decoder_unit.sv =====
// Pulse-distance IR bit decoder. Takes one measured cell (mark and period, in
// ticks) per clock unless the output stalls, and classifies it as a one
// (period/mark near 4), a zero (near 2) or invalid, using cross-multiplied
// compares against a window set by the tolerance register. Bits pack LSB
// first; each full byte goes out with its index, an invalid cell flushes the
// partial byte with tlast, and tlast also marks the byte at the frame limit.
// A frame-start item (tuser = 1) resets the frame and the next cell is taken
// as the leader and dropped. A cell passes the multiplier register, one slot
// in the two-entry cell queue, and the output register. Write the tolerance
// only while the block is idle.
module ir_pulse_distance_bit_decoder_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [irpd_pkg::TOL_W-1:0]           i_cfg_data,    // tolerance_percent
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [irpd_pkg::IN_TDATA_W-1:0]      i_s_tdata,     // mark_ticks, period_ticks
    input  logic                                 i_s_tuser,     // req_type
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [irpd_pkg::OUT_TDATA_W-1:0]     o_m_tdata,     // byte_value, byte_index,
                                                                // bits_valid, zero pad
    output logic                                 o_m_tlast
);

`include "assert_macros.svh"

    logic                 w_push;
    irpd_pkg::t_cell_cmd  w_push_cmd;
    logic                 w_pop;
    irpd_pkg::t_cell_cmd  w_head_cmd;
    irpd_pkg::t_q_status  w_q_status;
    irpd_pkg::t_out_item  w_out;
    logic                 w_full_byte;
    logic                 w_at_limit;
    logic                 w_bits_ok;

    irpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd)
    );

    irpd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_push_cmd(w_push_cmd),
        .i_pop     (w_pop),
        .o_head_cmd(w_head_cmd),
        .o_status  (w_q_status)
    );

    irpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_status(w_q_status),
        .i_head_cmd(w_head_cmd),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_item    (w_out),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {{irpd_pkg::OUT_PAD_W{1'b0}}, w_out};

    assign w_full_byte = (w_out.bits_valid == irpd_pkg::BITS_W'(irpd_pkg::BYTE_BITS));
    assign w_at_limit  = (w_out.byte_index == irpd_pkg::IDX_W'(irpd_pkg::FRAME_BYTES - 1));
    assign w_bits_ok   = (w_out.bits_valid <= irpd_pkg::BITS_W'(irpd_pkg::BYTE_BITS));

    `ASSERT_IMPLIES(a_push_has_room, i_clk, i_rst_n, w_push, !w_q_status.full)
    `ASSERT_IMPLIES(a_pop_has_item, i_clk, i_rst_n, w_pop, !w_q_status.empty)
    `ASSERT_IMPLIES(a_mid_frame_full, i_clk, i_rst_n, o_m_tvalid && !o_m_tlast, w_full_byte)
    `ASSERT_IMPLIES(a_limit_index, i_clk, i_rst_n, o_m_tvalid && o_m_tlast && w_full_byte, w_at_limit)
    `ASSERT_HOLDS(a_bits_range, i_clk, i_rst_n, !o_m_tvalid || w_bits_ok)

endmodule
